// ===== hw/rtl/arbl_pkg.sv =====
package arbl_pkg;

    localparam int MSG_W   = 17;
    localparam int SRC_W   = 8;
    localparam int DEC_W   = 2;
    localparam int STAMP_W = 48;
    localparam int LIMIT_W = 32;
    localparam int COUNT_W = 7;

    // slave tdata: msg | src | decision | time, padded to whole bytes
    localparam int S_DATA_W = 80;
    // master tdata: msg | src | count
    localparam int M_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 32'd8000;

    localparam logic REQ_OBSERVE = 1'b0;
    localparam logic REQ_PURGE   = 1'b1;

    localparam logic [DEC_W-1:0] DEC_ACCEPT   = 2'd0;
    localparam logic [DEC_W-1:0] DEC_REJ_PRIO = 2'd1;
    localparam logic [DEC_W-1:0] DEC_REJ_RULE = 2'd2;
    localparam logic [DEC_W-1:0] DEC_REJ_OTHR = 2'd3;

    typedef logic [MSG_W-1:0]   t_msg;
    typedef logic [SRC_W-1:0]   t_src;
    typedef logic [DEC_W-1:0]   t_dec;
    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        t_msg   msg;
        t_src   src;
        t_stamp stamp;
    } t_entry;

    typedef enum logic {
        ALU_MATCH = 1'b0,
        ALU_AGE   = 1'b1
    } t_alu_op;

endpackage

// ===== hw/rtl/arbitration_loser_table_aging_unit.sv =====
// Arbitration loser table with aging.
//
// Input beats (s side): tuser[0] = request kind (observe / purge). Observe
// beats look the (message number, source) pair up and then refresh, append
// or remove it according to the decision code. Purge beats drop entries older
// than the age limit, keep survivor order and list each survivor as one
// output beat, tuser[0] = 1, tlast on the final one. Observe beats, and a
// purge that leaves the table empty, give a single beat with tuser[0] = 0.
// Every output beat carries the entry count after the request.
// Age limit register, reset value 8000 ms: the user writes it through
// i_cfg_wr_en / i_cfg_wr_data only while the block is idle; it is not enforced.
// Timing: one table entry is scanned per cycle through the single memory read
// port and the shared compare/subtract unit. Observe: the scan stops at the
// first match or after the last entry; a remove then reads the last entry and
// writes it into the hole. Purge: the whole table is scanned, survivors are
// compacted and listed one per cycle while the sink is ready. A new request is
// taken only in idle; a result loaded into the output register waits there
// for the sink while the next request is scanned, so stalls lose nothing.
// Reset (synchronous, active low) empties the table by zeroing the count and
// restores the age limit; the memory itself needs no clearing pass.
module arbitration_loser_table_aging_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // msg_number[16:0], source_addr[24:17],
                                     // decision[26:25], time_ms[74:27], zero
    input  logic [0:0]  i_s_tuser,   // req_type
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // entry_msg_number[16:0],
                                     // entry_source[24:17], entry_count[31:25]
    output logic [0:0]  o_m_tuser,   // entry_valid
    output logic        o_m_tlast,   // last_item
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data  // age_limit_ms
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);  // count, 0..depth
    localparam int IW = $clog2(TABLE_DEPTH);      // table address

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_MOVE_RD = 7'b0000100,
        S_MOVE_WR = 7'b0001000,
        S_RESP    = 7'b0010000,
        S_LIST_RD = 7'b0100000,
        S_LIST_LD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;         // next address to read
    logic          r_chk_vld, n_chk_vld; // read data awaiting a check
    logic [CW-1:0] r_chk_idx, n_chk_idx; // address of that read data
    logic [CW-1:0] r_kept, n_kept;       // purge write pointer
    logic [IW-1:0] r_at, n_at;           // slot of the entry to remove

    logic              r_req, n_req;
    arbl_pkg::t_msg    r_msg, n_msg;
    arbl_pkg::t_src    r_src, n_src;
    arbl_pkg::t_dec    r_dec, n_dec;
    arbl_pkg::t_stamp  r_now, n_now;
    arbl_pkg::t_limit  r_limit;

    logic              r_m_valid, n_m_valid;
    logic              r_m_user, n_m_user;
    logic              r_m_last, n_m_last;
    arbl_pkg::t_msg    r_m_msg, n_m_msg;
    arbl_pkg::t_src    r_m_src, n_m_src;
    arbl_pkg::t_count  r_m_count, n_m_count;

    logic              w_rd_en, w_wr_en;
    logic [IW-1:0]     w_rd_addr, w_wr_addr;
    arbl_pkg::t_entry  w_rd_data, w_wr_data;
    arbl_pkg::t_alu_op w_alu_op;
    logic              w_alu_hit;
    logic              w_hit;
    logic              w_is_purge;
    logic              w_out_free;
    logic [CW-1:0]     w_last_idx;
    logic [CW-1:0]     w_next_idx;
    logic              w_list_last;

    arbl_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // one compare unit: pair match on observe, age test on purge
    arbl_alu u_alu (
        .i_op    (w_alu_op),
        .i_entry (w_rd_data),
        .i_msg   (r_msg),
        .i_src   (r_src),
        .i_now   (r_now),
        .i_limit (r_limit),
        .o_hit   (w_alu_hit)
    );

    assign w_is_purge  = (r_req == arbl_pkg::REQ_PURGE);
    assign w_alu_op    = w_is_purge ? arbl_pkg::ALU_AGE : arbl_pkg::ALU_MATCH;
    assign w_hit       = r_chk_vld && w_alu_hit;
    assign w_out_free  = !r_m_valid || i_m_tready;
    assign w_last_idx  = r_count - CW'(1);
    assign w_next_idx  = r_idx + CW'(1);
    assign w_list_last = (r_idx == w_last_idx);

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_kept    = r_kept;
        n_at      = r_at;
        n_req     = r_req;
        n_msg     = r_msg;
        n_src     = r_src;
        n_dec     = r_dec;
        n_now     = r_now;
        n_m_user  = r_m_user;
        n_m_last  = r_m_last;
        n_m_msg   = r_m_msg;
        n_m_src   = r_m_src;
        n_m_count = r_m_count;
        n_m_valid = i_m_tready ? 1'b0 : r_m_valid;

        w_rd_en   = 1'b0;
        w_rd_addr = r_idx[IW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_kept[IW-1:0];
        w_wr_data = w_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_req     = i_s_tuser[0];
                    n_msg     = i_s_tdata[16:0];
                    n_src     = i_s_tdata[24:17];
                    n_dec     = i_s_tdata[26:25];
                    n_now     = i_s_tdata[74:27];
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    n_kept    = '0;
                    n_state   = S_SCAN;
                end
            end

            S_SCAN: begin
                // read one entry per cycle, check the previous one
                w_rd_en   = (r_idx < r_count);
                n_chk_vld = w_rd_en;
                n_chk_idx = r_idx;
                if (w_rd_en) begin
                    n_idx = w_next_idx;
                end
                if (w_is_purge && w_hit) begin
                    // survivor: compact towards the front
                    w_wr_en = 1'b1;
                    n_kept  = r_kept + CW'(1);
                end
                if ((!w_is_purge && w_hit) || !w_rd_en) begin
                    if (w_is_purge) begin
                        n_count = n_kept;
                        n_idx   = '0;
                        n_state = (n_kept == '0) ? S_RESP : S_LIST_RD;
                    end else begin
                        n_state = S_RESP;
                        case (r_dec)
                            arbl_pkg::DEC_REJ_PRIO, arbl_pkg::DEC_REJ_RULE: begin
                                w_wr_data = '{msg: r_msg, src: r_src, stamp: r_now};
                                if (w_hit) begin
                                    w_wr_en   = 1'b1;
                                    w_wr_addr = r_chk_idx[IW-1:0];
                                end else if (r_count < CW'(TABLE_DEPTH)) begin
                                    w_wr_en   = 1'b1;
                                    w_wr_addr = r_count[IW-1:0];
                                    n_count   = r_count + CW'(1);
                                end
                            end
                            arbl_pkg::DEC_ACCEPT: begin
                                if (w_hit) begin
                                    n_at    = r_chk_idx[IW-1:0];
                                    n_state = S_MOVE_RD;
                                end
                            end
                            default: begin
                                n_state = S_RESP;
                            end
                        endcase
                    end
                end
            end

            S_MOVE_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_last_idx[IW-1:0];
                n_state   = S_MOVE_WR;
            end

            S_MOVE_WR: begin
                // last entry fills the hole
                w_wr_en   = 1'b1;
                w_wr_addr = r_at;
                n_count   = w_last_idx;
                n_state   = S_RESP;
            end

            S_RESP: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b0;
                    n_m_msg   = '0;
                    n_m_src   = '0;
                    n_m_count = arbl_pkg::t_count'(r_count);
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            S_LIST_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx[IW-1:0];
                n_state   = S_LIST_LD;
            end

            S_LIST_LD: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = 1'b1;
                    n_m_msg   = w_rd_data.msg;
                    n_m_src   = w_rd_data.src;
                    n_m_count = arbl_pkg::t_count'(r_count);
                    n_m_last  = w_list_last;
                    if (w_list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next survivor behind this beat
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_next_idx[IW-1:0];
                        n_idx     = w_next_idx;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_m_valid <= 1'b0;
            r_limit   <= arbl_pkg::AGE_LIMIT_RESET;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_m_valid <= n_m_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_kept    <= n_kept;
        r_at      <= n_at;
        r_req     <= n_req;
        r_msg     <= n_msg;
        r_src     <= n_src;
        r_dec     <= n_dec;
        r_now     <= n_now;
        r_m_user  <= n_m_user;
        r_m_last  <= n_m_last;
        r_m_msg   <= n_m_msg;
        r_m_src   <= n_m_src;
        r_m_count <= n_m_count;
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = {r_m_count, r_m_src, r_m_msg};
    assign o_m_tuser[0] = r_m_user;
    assign o_m_tlast    = r_m_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rd_en && w_wr_en && (w_rd_addr == w_wr_addr)))
        else $error("read and write to the same slot in one cycle");

    a_kept_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_is_purge && r_chk_vld) |-> (r_kept <= r_chk_idx))
        else $error("purge write pointer overtook the scan");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_tready) |=> (r_m_valid && $stable(o_m_tdata)))
        else $error("stalled result overwritten");
`endif

endmodule

// ===== hw/rtl/arbl_table.sv =====
module arbl_table #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output arbl_pkg::t_entry  o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  arbl_pkg::t_entry  i_wr_data
);

    // contents undefined until written; only entries below the count are read
    arbl_pkg::t_entry r_mem [DEPTH];
    arbl_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/arbl_alu.sv =====
module arbl_alu (
    input  arbl_pkg::t_alu_op i_op,
    input  arbl_pkg::t_entry  i_entry,
    input  arbl_pkg::t_msg    i_msg,
    input  arbl_pkg::t_src    i_src,
    input  arbl_pkg::t_stamp  i_now,
    input  arbl_pkg::t_limit  i_limit,
    output logic              o_hit
);

    arbl_pkg::t_stamp w_age;

    // modular age, wraps with the timebase
    assign w_age = i_now - i_entry.stamp;

    always_comb begin
        case (i_op)
            arbl_pkg::ALU_MATCH: o_hit = (i_entry.msg == i_msg) && (i_entry.src == i_src);
            arbl_pkg::ALU_AGE:   o_hit = (w_age <= arbl_pkg::t_stamp'(i_limit));
            default:             o_hit = 1'b0;
        endcase
    end

endmodule

// ===== dv/arbitration_loser_table_aging_unit_test.sv =====
module arbitration_loser_table_aging_unit_test;
    import arbl_pkg::*;

    localparam int TABLE_DEPTH      = 64;
    // a full scan plus the remove shuffle, with margin
    localparam int SETTLE_CYCLES    = TABLE_DEPTH + 16;
    // long sink hold-off: enough for the block to back up into its input
    localparam int SINK_HOLD_CYCLES = 300;
    // cycles with no beat on either side and no register write
    localparam int WATCHDOG_LIMIT   = 4000;

    // one output beat as the block should present it
    typedef struct {
        logic   listed;   // tuser[0], entry_valid
        t_msg   msg;
        t_src   src;
        t_count count;
        logic   last;
    } t_loser_beat;

    // Shadow copy of the loser table. Every accepted request updates it and
    // queues the beats it must produce; every output beat is checked against
    // the oldest one queued.
    class loser_table_tracker;
        t_entry      held[$];
        t_loser_beat due[$];
        t_limit      age_limit    = AGE_LIMIT_RESET;
        int          n_mismatches = 0;

        function void queue_beat(logic listed, t_msg msg, t_src src, logic last);
            t_loser_beat b;
            b.listed = listed;
            b.msg    = msg;
            b.src    = src;
            b.count  = t_count'(held.size());
            b.last   = last;
            due.push_back(b);
        endfunction

        function void note_request(logic kind, t_msg msg, t_src src, t_dec dec,
                                   t_stamp now);
            t_entry kept[$];
            t_entry e;
            t_stamp age;
            int     at;
            at = -1;
            if (kind == REQ_OBSERVE) begin
                foreach (held[i])
                    if (at < 0 && held[i].msg == msg && held[i].src == src)
                        at = i;
                if (dec == DEC_REJ_PRIO || dec == DEC_REJ_RULE) begin
                    if (at >= 0) begin
                        e = held[at];
                        e.stamp = now;
                        held[at] = e;
                    end else if (held.size() < TABLE_DEPTH) begin
                        // a full table silently drops the new loser
                        held.push_back({msg, src, now});
                    end
                end else if (dec == DEC_ACCEPT && at >= 0) begin
                    // last entry fills the hole
                    held[at] = held[held.size() - 1];
                    void'(held.pop_back());
                end
                queue_beat(1'b0, '0, '0, 1'b1);
            end else begin
                // age is modulo 2^48, so a stamp ahead of now looks ancient
                foreach (held[i]) begin
                    age = now - held[i].stamp;
                    if (age <= t_stamp'(age_limit))
                        kept.push_back(held[i]);
                end
                held = kept;
                if (held.size() == 0)
                    queue_beat(1'b0, '0, '0, 1'b1);
                else
                    foreach (held[i])
                        queue_beat(1'b1, held[i].msg, held[i].src,
                                   i == held.size() - 1);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                n_mismatches++;
            end
        endfunction

        function void check_beat(logic listed, logic [M_DATA_W-1:0] data, logic last);
            t_loser_beat b;
            if (due.size() == 0) begin
                $error("unexpected beat: tuser %0h tdata %0h tlast %0h",
                       listed, data, last);
                n_mismatches++;
                return;
            end
            b = due.pop_front();
            compare_field("entry_valid",      32'(b.listed), 32'(listed));
            compare_field("entry_msg_number", 32'(b.msg),    32'(data[16:0]));
            compare_field("entry_source",     32'(b.src),    32'(data[24:17]));
            compare_field("entry_count",      32'(b.count),  32'(data[31:25]));
            compare_field("last_item",        32'(b.last),   32'(last));
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_s_tvalid    = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata     = '0;
    logic [0:0]          i_s_tuser     = '0;
    logic                o_m_tvalid;
    logic                i_m_tready    = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic [0:0]          o_m_tuser;
    logic                o_m_tlast;
    logic                i_cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_wr_data = '0;

    loser_table_tracker loser_table;

    bit     quiet_tail       = 1'b0;   // no idling on either side once set
    int     sink_holds_asked = 0;
    int     sink_holds_done  = 0;
    int     stall_cycles     = 0;
    t_stamp stamp_now;                 // running bus time for random phases

    arbitration_loser_table_aging_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Offer one request and hold it until the block takes it. An optional
    // idle burst goes in front. The request is noted at the accepting edge.
    task automatic send_request(logic kind, t_msg msg, t_src src, t_dec dec,
                                t_stamp now);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        // tdata from bit 0: msg, src, decision, time, zero pad
        i_s_tdata  <= {5'b0, now, dec, src, msg};
        do @(posedge i_clk); while (!o_s_tready);
        loser_table.note_request(kind, msg, src, dec, now);
    endtask

    // stop offering and wait for every outstanding beat
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (loser_table.due.size() != 0) @(posedge i_clk);
    endtask

    // register writes only with the block idle: drained, then given time to
    // finish any trailing table shuffle
    task automatic set_age_limit(t_limit limit);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        loser_table.age_limit = limit;
    endtask

    // Random phase: mostly observe beats on a pool of recurring pairs, so
    // refresh and remove really hit stored entries, a sprinkle of purges,
    // and some noise (fresh pairs, time jumps). Fill mode leans on rejects
    // with a wide pool and a huge age limit to run the table full.
    task automatic run_phase(t_limit limit, int n_items, int pool_n,
                             int unsigned step_max, bit fill, int hold_at);
        t_msg pool_msg[$];
        t_src pool_src[$];
        t_msg msg;
        t_src src;
        t_dec dec;
        logic kind;
        int   pick;
        int   roll;
        set_age_limit(limit);
        repeat (pool_n) begin
            pool_msg.push_back(t_msg'($urandom));
            pool_src.push_back(t_src'($urandom));
        end
        for (int n = 0; n < n_items; n++) begin
            if (n == hold_at)
                sink_holds_asked++;
            roll = $urandom_range(0, 99);
            kind = (roll < (fill ? 3 : 10)) ? REQ_PURGE : REQ_OBSERVE;
            pick = $urandom_range(0, pool_n - 1);
            msg  = pool_msg[pick];
            src  = pool_src[pick];
            if (roll >= 95) begin
                msg = t_msg'($urandom);
                src = t_src'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (roll < (fill ? 92 : 55))
                dec = $urandom_range(0, 1) ? DEC_REJ_PRIO : DEC_REJ_RULE;
            else if (roll < (fill ? 97 : 90))
                dec = DEC_ACCEPT;
            else
                dec = DEC_REJ_OTHR;
            if (!fill && $urandom_range(0, 49) == 0)
                stamp_now = t_stamp'({$urandom, $urandom});
            else
                stamp_now += $urandom_range(0, step_max);
            send_request(kind, msg, src, dec, stamp_now);
        end
    endtask

    // Sink: random ready bursts, plus the long hold-off when asked for.
    initial begin : sink
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (sink_holds_done != sink_holds_asked) begin
                sink_holds_done++;
                i_m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // output beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            loser_table.check_beat(o_m_tuser[0], o_m_tdata, o_m_tlast);
    end

    // watchdog: too long with nothing moving means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || i_cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("arbitration_loser_table_aging_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        t_stamp base;
        t_limit rand_limit;
        loser_table = new;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset limit of 8000 ms. Base sits 4000 ms
        // short of the 48-bit wrap, so the purge below ages across it.
        base = 48'hFFFF_FFFF_F060;
        send_request(REQ_PURGE,   '0,       '0,    DEC_ACCEPT,   base);       // empty list
        send_request(REQ_OBSERVE, '0,       '0,    DEC_ACCEPT,   base);       // accept, absent
        send_request(REQ_OBSERVE, 17'h1FFFF, 8'hFF, DEC_REJ_OTHR, base);      // no change
        send_request(REQ_OBSERVE, 17'h1FFFF, 8'hFF, DEC_REJ_PRIO, base - 1);  // append
        send_request(REQ_OBSERVE, '0,       '0,    DEC_REJ_RULE, base);
        send_request(REQ_OBSERVE, 17'h15555, 8'hAA, DEC_REJ_RULE, base);
        send_request(REQ_OBSERVE, 17'h0AAAA, 8'h55, DEC_REJ_PRIO, base);
        send_request(REQ_OBSERVE, '0,       '0,    DEC_REJ_PRIO, base + 5000); // refresh, wraps
        send_request(REQ_OBSERVE, 17'h15555, 8'hAA, DEC_REJ_OTHR, base + 9000); // no refresh
        send_request(REQ_OBSERVE, 17'h00F0F, 8'h0F, DEC_REJ_PRIO, base + 9000); // future stamp
        send_request(REQ_OBSERVE, 17'h0AAAA, 8'h55, DEC_ACCEPT,   base);        // last fills hole
        // ages 8001 (drop), 3000, exactly 8000 (kept), and negative (drop)
        send_request(REQ_PURGE,   17'h1FFFF, 8'hFF, DEC_REJ_OTHR, base + 8000);
        send_request(REQ_OBSERVE, '0,       '0,    DEC_ACCEPT,   base + 8000); // head removed
        send_request(REQ_OBSERVE, 17'h15555, 8'hAA, DEC_ACCEPT,   base + 8000); // only one left
        send_request(REQ_PURGE,   '0,       '0,    DEC_ACCEPT,   base + 8000);

        // zero limit: only same-millisecond entries survive
        set_age_limit('0);
        send_request(REQ_OBSERVE, 17'h01234, 8'h12, DEC_REJ_RULE, 48'h8000_0000_0000);
        send_request(REQ_PURGE,   '0,       '0,    DEC_ACCEPT,   48'h8000_0000_0000);
        send_request(REQ_PURGE,   '0,       '0,    DEC_ACCEPT,   48'h8000_0000_0001);

        // widest limit, right at its edge
        set_age_limit('1);
        send_request(REQ_OBSERVE, 17'h10000, 8'h80, DEC_REJ_PRIO, '0);
        send_request(REQ_PURGE,   '0,       '0,    DEC_ACCEPT,   48'h0000_FFFF_FFFF);
        send_request(REQ_PURGE,   '0,       '0,    DEC_ACCEPT,   48'h0001_0000_0000);

        // random phases; the fill phase holds the sink mid-way with the
        // table nearly full, so long listings back up into the input
        stamp_now = t_stamp'({$urandom, $urandom});
        run_phase(AGE_LIMIT_RESET, 90, 24, 1500, 1'b0, -1);
        run_phase('1, 130, 200, 50, 1'b1, 80);
        run_phase('0, 40, 8, 1, 1'b0, -1);
        rand_limit = $urandom;
        run_phase(rand_limit, 60, 40, rand_limit >> 2, 1'b0, -1);
        quiet_tail = 1'b1;
        run_phase(32'd1000, 90, 16, 300, 1'b0, -1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (loser_table.n_mismatches == 0 && loser_table.due.size() == 0)
            $display("arbitration_loser_table_aging_unit test passed");
        else
            $display("arbitration_loser_table_aging_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/arbl_pkg.sv
hw/rtl/arbl_table.sv
hw/rtl/arbl_alu.sv
hw/rtl/arbitration_loser_table_aging_unit.sv
dv/arbitration_loser_table_aging_unit_test.sv
